[src/ari_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ari_pkg: shared constants for the adjusted Rand index evaluator
// Field widths and offsets of the stream payloads, register indexes, caps of
// the fixed-point result and parameter defaults.
// ----------------------------------------------------------------------------
package ari_pkg;

  // parameter defaults
  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int MAX_POINTS_DEF   = 4096;

  // input payload
  localparam int ID_W        = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int CLUSTER_LSB = 0;
  localparam int CLASS_LSB   = 4;

  // result payload
  localparam int ARI_W       = 18;
  localparam int PAIRS_W     = 23;
  localparam int OUT_TDATA_W = 48;
  localparam int ARI_LSB     = 0;
  localparam int PAIRS_LSB   = 18;
  localparam int UNDEF_BIT   = 41;
  localparam int SAT_BIT     = 42;

  // caps of the Q.16 index
  localparam logic [ARI_W-1:0] ARI_POS_CAP = 18'd65536;
  localparam logic [ARI_W-1:0] ARI_NEG_CAP = 18'd131072;

  // quotient bits produced by the divider, one per cycle
  localparam int DIV_STEPS = ARI_W;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_ENABLE = 1'b0;

endpackage

[src/ari_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ari_ram: generic single-write, single-read synchronous RAM
// Read data is registered; a read of the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
module ari_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/adjusted_rand_index_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjusted_rand_index_eval: streaming adjusted Rand index of a clustering
// Counts pairs incrementally from one point per transfer; on a set's last point
// emits the index in signed Q.16 (zero unless enable_accuracy) with the pair count.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload (low bit up)                          | Per
//  ---------+-----+-----------------------------------------------+-----------
//  s_axis   | in  | cluster_id[3:0], class_label[7:4]; tlast=last | point
//  m_axis   | out | ari[17:0], same_both_pairs[40:18],            | data set
//           |     | undefined[41], saturated[42], zero pad        |
//  apb      | in  | reg 0 @ 0x0: enable_accuracy (bit 0)          | write
//
//  Points are taken one per cycle when input is not held off: each does a
//  read-modify-write on three count memories (pair table, cluster counts,
//  class counts), with the last written entry forwarded so back-to-back
//  points on one entry count right. The cycle after a last point stalls
//  input, and input stays held off until the result is loaded. The result
//  follows that stall cycle, 4 passes of one shared multiplier, a prepare
//  and a check state, a restoring divider (one quotient bit per cycle) and
//  the load of the output register. In parallel a clearing pass writes zero
//  to every memory entry, one per cycle, over all 2^(2*clog2(MAX_CLUSTERS))
//  pair table addresses (256 at 16 clusters); input is held off until it
//  ends. Reset starts the same pass. A result waiting in the output register
//  does not stall input; the next result waits for it to be taken.
// ----------------------------------------------------------------------------
module adjusted_rand_index_eval
  import ari_pkg::*;
#(
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF,
  parameter int MAX_POINTS   = MAX_POINTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // point stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // cluster_id[3:0], class_label[7:4]
  input  logic                   s_axis_tlast,
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // ari[17:0], same_both_pairs[40:18],
                                                 // undefined[41], saturated[42]
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [CFG_ADDR_W-1:0]  paddr,
  input  logic [CFG_DATA_W-1:0]  pwdata,
  output logic [CFG_DATA_W-1:0]  prdata,
  output logic                   pready
);

  // widths that follow from the parameters
  localparam int KW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int AW   = 2 * KW;                 // pair table address
  localparam int CW   = $clog2(MAX_POINTS + 1); // point counts
  localparam int PSW  = 2 * CW - 1;             // pair sums, at most N(N-1)/2
  localparam int MW   = PSW + 1;                // multiplier operands
  localparam int PW   = 2 * MW;                 // products
  localparam int DW   = PW + 3;                 // divider remainder
  localparam int SW   = $clog2(DIV_STEPS);      // step counter

  // multiplier passes
  localparam logic [SW-1:0] MUL_T  = SW'(0);
  localparam logic [SW-1:0] MUL_P  = SW'(1);
  localparam logic [SW-1:0] MUL_Q  = SW'(2);
  localparam logic [SW-1:0] MUL_DL = SW'(3);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MUL,
    ST_PREP,
    ST_CHK,
    ST_DIV,
    ST_OUT
  } state_e;

  // fold an input id onto the table
  function automatic logic [KW-1:0] wrap_id(input logic [ID_W-1:0] v);
    logic [KW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << ID_W); i++) begin
      if (v == ID_W'(i)) begin
        r = KW'(i % MAX_CLUSTERS);
      end
    end
    return r;
  endfunction

  state_e            state_q;
  logic [SW-1:0]     step_q;
  logic              clr_busy_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              m_tvalid_q;
  logic [OUT_TDATA_W-1:0] m_tdata_q;
  logic              enable_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_ENABLE);
  assign prdata = (paddr[2] == REG_IDX_ENABLE) ? CFG_DATA_W'(enable_q) : '0;

  // ---------------------------------------------------------------------------
  // Input acceptance and count stage
  // ---------------------------------------------------------------------------
  logic          s1_valid_q, s1_last_q;
  logic [KW-1:0] s1_c_q, s1_l_q;
  logic [KW-1:0] in_c, in_l;
  logic          in_xfer;

  // hold off input while the last point of a set is still being counted
  assign s_axis_tready = (state_q == ST_RUN) && !clr_busy_q && !(s1_valid_q && s1_last_q);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_c          = wrap_id(s_axis_tdata[CLUSTER_LSB +: ID_W]);
  assign in_l          = wrap_id(s_axis_tdata[CLASS_LSB +: ID_W]);

  logic [CW-1:0]  point_cnt_q;
  logic [PSW-1:0] both_sum_q, clu_sum_q, cls_sum_q;
  logic           ovf_q;
  logic           counted;

  assign counted = s1_valid_q && (point_cnt_q < CW'(MAX_POINTS));

  // memory ports
  logic [CW-1:0] pt_rdata, cc_rdata, lc_rdata;
  logic [CW-1:0] pt_old, cc_old, lc_old;
  logic          mem_we;
  logic [AW-1:0] pt_waddr;
  logic [KW-1:0] cc_waddr, lc_waddr;
  logic [CW-1:0] pt_wdata, cc_wdata, lc_wdata;

  // last write of each memory, forwarded to the point right behind it
  logic          pt_fwd_v_q, cc_fwd_v_q, lc_fwd_v_q;
  logic [AW-1:0] pt_fwd_a_q;
  logic [KW-1:0] cc_fwd_a_q, lc_fwd_a_q;
  logic [CW-1:0] pt_fwd_d_q, cc_fwd_d_q, lc_fwd_d_q;

  assign pt_old = (pt_fwd_v_q && pt_fwd_a_q == {s1_c_q, s1_l_q}) ? pt_fwd_d_q : pt_rdata;
  assign cc_old = (cc_fwd_v_q && cc_fwd_a_q == s1_c_q) ? cc_fwd_d_q : cc_rdata;
  assign lc_old = (lc_fwd_v_q && lc_fwd_a_q == s1_l_q) ? lc_fwd_d_q : lc_rdata;

  // the clearing pass owns the write port while it runs
  assign mem_we   = counted || clr_busy_q;
  assign pt_waddr = clr_busy_q ? clr_cnt_q : {s1_c_q, s1_l_q};
  assign cc_waddr = clr_busy_q ? clr_cnt_q[KW-1:0] : s1_c_q;
  assign lc_waddr = clr_busy_q ? clr_cnt_q[KW-1:0] : s1_l_q;
  assign pt_wdata = clr_busy_q ? '0 : pt_old + CW'(1);
  assign cc_wdata = clr_busy_q ? '0 : cc_old + CW'(1);
  assign lc_wdata = clr_busy_q ? '0 : lc_old + CW'(1);

  ari_ram #(.WIDTH(CW), .DEPTH(1 << AW)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i ({in_c, in_l}),
    .rdata_o (pt_rdata)
  );

  ari_ram #(.WIDTH(CW), .DEPTH(1 << KW)) u_cluster_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cc_waddr),
    .wdata_i (cc_wdata),
    .raddr_i (in_c),
    .rdata_o (cc_rdata)
  );

  ari_ram #(.WIDTH(CW), .DEPTH(1 << KW)) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (lc_waddr),
    .wdata_i (lc_wdata),
    .raddr_i (in_l),
    .rdata_o (lc_rdata)
  );

  // ---------------------------------------------------------------------------
  // Final arithmetic: shared multiplier, then restoring divider
  // ---------------------------------------------------------------------------
  logic [PSW-1:0] t_q;
  logic [PW-1:0]  p_q, q_q, dl_q;
  logic [MW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  mul_p;
  logic [CW-1:0]  n_minus1;
  logic [MW-1:0]  sb_plus_sc;

  assign n_minus1   = point_cnt_q - CW'(1);
  assign sb_plus_sc = {1'b0, clu_sum_q} + {1'b0, cls_sum_q};

  always_comb begin
    case (step_q)
      MUL_T: begin
        mul_a = MW'(point_cnt_q);
        mul_b = MW'(n_minus1);
      end
      MUL_P: begin
        mul_a = MW'(both_sum_q);
        mul_b = MW'(t_q);
      end
      MUL_Q: begin
        mul_a = MW'(clu_sum_q);
        mul_b = MW'(cls_sum_q);
      end
      default: begin
        mul_a = sb_plus_sc;
        mul_b = MW'(t_q);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // prepare numerator and denominator
  logic [PW:0]   dl_ext, dr, den;
  logic          prep_undef, prep_neg;
  logic [PW-1:0] prep_diff;

  assign dl_ext     = {1'b0, dl_q};
  assign dr         = {q_q, 1'b0};
  assign prep_undef = (dl_ext <= dr);
  assign prep_neg   = (p_q < q_q);
  assign prep_diff  = prep_neg ? (q_q - p_q) : (p_q - q_q);
  assign den        = dl_ext - dr;

  logic [DW-1:0]    num_q, den4_q, rem_q;
  logic             neg_q, undef_q, big_q;
  logic [ARI_W-1:0] quo_q;
  logic [DW:0]      div_r2;
  logic             div_ge;

  // remainder is kept below four times the denominator when the quotient does not saturate
  assign div_r2 = {rem_q, 1'b0};
  assign div_ge = (div_r2 >= {1'b0, den4_q});

  // result composition
  logic [PSW-1:0]   a_out_q;
  logic             sat_out_q;
  logic [ARI_W-1:0] ari_mag, ari_val;
  logic             res_undef;

  always_comb begin
    if (neg_q) begin
      ari_mag = (big_q || quo_q > ARI_NEG_CAP) ? ARI_NEG_CAP : quo_q;
    end else begin
      ari_mag = (big_q || quo_q > ARI_POS_CAP) ? ARI_POS_CAP : quo_q;
    end
    res_undef = enable_q && undef_q;
    if (!enable_q || undef_q) begin
      ari_val = '0;
    end else if (neg_q) begin
      ari_val = '0 - ari_mag;
    end else begin
      ari_val = ari_mag;
    end
  end

  logic out_load;
  assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_axis_tready);

  // ---------------------------------------------------------------------------
  // Sequencer: state, step count, clearing pass, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      step_q     <= '0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      // clearing pass
      if (s1_valid_q && s1_last_q) begin
        clr_busy_q <= 1'b1;
        clr_cnt_q  <= '0;
      end else if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == '1) begin
          clr_busy_q <= 1'b0;
        end
      end

      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_RUN: begin
          if (s1_valid_q && s1_last_q) begin
            state_q <= ST_MUL;
            step_q  <= MUL_T;
          end
        end
        ST_MUL: begin
          if (step_q == MUL_DL) begin
            state_q <= ST_PREP;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        ST_PREP: begin
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          state_q <= ST_DIV;
          step_q  <= '0;
        end
        ST_DIV: begin
          if (step_q == SW'(DIV_STEPS - 1)) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_RUN;
          end
        end
        default: begin
          state_q <= ST_RUN;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Count stage control and pair sums
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      point_cnt_q <= '0;
      both_sum_q  <= '0;
      clu_sum_q   <= '0;
      cls_sum_q   <= '0;
      ovf_q       <= 1'b0;
      pt_fwd_v_q  <= 1'b0;
      cc_fwd_v_q  <= 1'b0;
      lc_fwd_v_q  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        enable_q <= pwdata[0];
      end
      s1_valid_q <= in_xfer;
      s1_last_q  <= in_xfer && s_axis_tlast;
      pt_fwd_v_q <= counted;
      cc_fwd_v_q <= counted;
      lc_fwd_v_q <= counted;

      if (counted) begin
        both_sum_q  <= both_sum_q + PSW'(pt_old);
        clu_sum_q   <= clu_sum_q + PSW'(cc_old);
        cls_sum_q   <= cls_sum_q + PSW'(lc_old);
        point_cnt_q <= point_cnt_q + CW'(1);
      end else if (s1_valid_q) begin
        ovf_q <= 1'b1;
      end

      // sums are consumed by the multiplier passes; drop them for the next set
      if (state_q == ST_PREP) begin
        both_sum_q  <= '0;
        clu_sum_q   <= '0;
        cls_sum_q   <= '0;
        point_cnt_q <= '0;
        ovf_q       <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_c_q <= in_c;
      s1_l_q <= in_l;
    end
    if (counted) begin
      pt_fwd_a_q <= {s1_c_q, s1_l_q};
      pt_fwd_d_q <= pt_wdata;
      cc_fwd_a_q <= s1_c_q;
      cc_fwd_d_q <= cc_wdata;
      lc_fwd_a_q <= s1_l_q;
      lc_fwd_d_q <= lc_wdata;
    end

    if (state_q == ST_MUL) begin
      case (step_q)
        MUL_T:   t_q  <= PSW'(mul_p >> 1);
        MUL_P:   p_q  <= mul_p;
        MUL_Q:   q_q  <= mul_p;
        default: dl_q <= mul_p;
      endcase
    end

    if (state_q == ST_PREP) begin
      num_q     <= DW'({prep_diff, 1'b0});
      den4_q    <= {den, 2'b00};
      neg_q     <= prep_neg;
      undef_q   <= prep_undef;
      a_out_q   <= both_sum_q;
      sat_out_q <= ovf_q;
    end

    if (state_q == ST_CHK) begin
      // a quotient of four or more saturates either cap
      big_q <= (num_q >= den4_q);
      rem_q <= num_q;
    end

    if (state_q == ST_DIV) begin
      rem_q <= div_ge ? DW'(div_r2 - {1'b0, den4_q}) : DW'(div_r2);
      quo_q <= {quo_q[ARI_W-2:0], div_ge};
    end

    if (out_load) begin
      // fields sit back to back from bit 0 up, zero pad on top
      m_tdata_q <= OUT_TDATA_W'({sat_out_q, res_undef, PAIRS_W'(a_out_q), ari_val});
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

endmodule

[src/ari_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ari_checker: port-level checks for the adjusted Rand index evaluator
// Watches the stream and configuration ports and flags results or
// handshakes that break the block's contract.
// ----------------------------------------------------------------------------
module ari_checker
  import ari_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tlast,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a pending result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped before transfer");

  // the point after a last transfer is never taken in the next cycle
  a_last_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input taken right after last point");

  // an undefined index reads zero
  a_undef_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[UNDEF_BIT] |-> m_axis_tdata[ARI_LSB +: ARI_W] == '0)
    else $error("undefined result with nonzero index");

  // a positive index never exceeds one
  a_pos_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[ARI_LSB + ARI_W - 1]
      |-> m_axis_tdata[ARI_LSB +: ARI_W] <= ARI_POS_CAP)
    else $error("index above one");

endmodule

bind adjusted_rand_index_eval ari_checker u_ari_checker (.*);
